// File: sv/oal_pkg.sv
`timescale 1ns / 1ps

package oal_pkg;

    localparam int CAPACITY = 64;
    localparam int AW       = $clog2(CAPACITY);
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int DW       = 32;

    typedef enum logic [2:0] {
        K_INSERT = 3'd0,
        K_DELETE = 3'd1,
        K_GET    = 3'd2,
        K_PREV   = 3'd3,
        K_NEXT   = 3'd4,
        K_SORT   = 3'd5,
        K_CLEAR  = 3'd6,
        K_NONE   = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        S_OK    = 2'd0,
        S_RANGE = 2'd1,
        S_FULL  = 2'd2,
        S_RSVD  = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]           kind;
        logic [CW-1:0]        position;
        logic signed [DW-1:0] value_in;
    } t_cmd;

    typedef struct packed {
        logic signed [DW-1:0] value_out;
        logic [1:0]           status;
        logic [CW-1:0]        count;
        logic                 is_empty;
    } t_result;

    typedef struct packed {
        logic          en;
        logic [AW-1:0] addr;
        logic [DW-1:0] data;
    } t_mem_wr;

endpackage

// File: sv/oal_store.sv
`timescale 1ns / 1ps

module oal_store (
    input  logic                     i_clk,
    input  oal_pkg::t_mem_wr         i_wr,
    input  logic [oal_pkg::AW-1:0]   i_raddr,
    output logic [oal_pkg::DW-1:0]   o_rdata
);

    logic [oal_pkg::DW-1:0] r_mem [oal_pkg::CAPACITY];
    logic [oal_pkg::DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/ordered_array_list_engine_core.sv
`timescale 1ns / 1ps
// errors, clear and trivial sort go straight from accept to the result strobe; get/previous/next
// read the store once; insert shifts the elements at and above position up one slot, delete reads the element
// then shifts the rest down one slot, and sort runs passes of compares through one comparator
// one transaction at a time: busy stays high through the strobe cycle, a new start is taken next cycle
// list elements live in a single-port-write / registered-read store; each shift step is read then write
// synchronous active-low reset empties the list; the receiver cannot stall the result strobe

module ordered_array_list_engine_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  oal_pkg::t_cmd     i_cmd,
    output logic              o_valid,
    output oal_pkg::t_result  o_result
);

    localparam int AW = oal_pkg::AW;
    localparam int CW = oal_pkg::CW;
    localparam int DW = oal_pkg::DW;

    typedef enum logic [9:0] {
        ST_IDLE      = 10'b00_0000_0001,
        ST_FETCH     = 10'b00_0000_0010,
        ST_INS_RD    = 10'b00_0000_0100,
        ST_INS_WR    = 10'b00_0000_1000,
        ST_DEL_RD    = 10'b00_0001_0000,
        ST_DEL_WR    = 10'b00_0010_0000,
        ST_SORT_HEAD = 10'b00_0100_0000,
        ST_SORT_RD   = 10'b00_1000_0000,
        ST_SORT_CMP  = 10'b01_0000_0000,
        ST_DONE      = 10'b10_0000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_end, n_end;
    logic [CW-1:0]     r_pos, n_pos;
    logic [2:0]        r_kind, n_kind;
    logic [DW-1:0]     r_val, n_val;
    logic [DW-1:0]     r_a, n_a;
    logic [DW-1:0]     r_value, n_value;
    oal_pkg::t_status  r_status, n_status;

    oal_pkg::t_mem_wr  mem_wr;
    logic [AW-1:0]     mem_raddr;
    logic [DW-1:0]     mem_rdata;
    logic              accept;
    logic              a_gt_b;
    logic [CW-1:0]     pos_m1;
    logic [CW-1:0]     pos_m2;
    logic [CW-1:0]     idx_m1;
    logic [CW-1:0]     idx_p1;

    oal_store u_store (
        .i_clk   (i_clk),
        .i_wr    (mem_wr),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign accept = start && !busy;
    assign pos_m1 = i_cmd.position - CW'(1);
    assign pos_m2 = i_cmd.position - CW'(2);
    assign idx_m1 = r_idx - CW'(1);
    assign idx_p1 = r_idx + CW'(1);

    // the one shared compare unit, used by every sort compare step
    assign a_gt_b = $signed(r_a) > $signed(mem_rdata);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_end     = r_end;
        n_pos     = r_pos;
        n_kind    = r_kind;
        n_val     = r_val;
        n_a       = r_a;
        n_value   = r_value;
        n_status  = r_status;
        mem_wr    = '0;
        mem_raddr = '0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_kind   = i_cmd.kind;
                    n_pos    = i_cmd.position;
                    n_val    = i_cmd.value_in;
                    n_value  = '0;
                    n_status = oal_pkg::S_OK;
                    n_state  = ST_DONE;
                    case (oal_pkg::t_kind'(i_cmd.kind))
                        oal_pkg::K_INSERT: begin
                            if (i_cmd.position > r_count) begin
                                n_status = oal_pkg::S_RANGE;
                            end else if (r_count == CW'(oal_pkg::CAPACITY)) begin
                                n_status = oal_pkg::S_FULL;
                            end else begin
                                n_idx   = r_count;
                                n_state = ST_INS_RD;
                            end
                        end
                        oal_pkg::K_DELETE, oal_pkg::K_GET: begin
                            if (i_cmd.position == '0 || i_cmd.position > r_count) begin
                                n_status = oal_pkg::S_RANGE;
                            end else begin
                                mem_raddr = pos_m1[AW-1:0];
                                n_state   = ST_FETCH;
                            end
                        end
                        oal_pkg::K_PREV: begin
                            if (i_cmd.position < CW'(2) || i_cmd.position > r_count) begin
                                n_status = oal_pkg::S_RANGE;
                            end else begin
                                mem_raddr = pos_m2[AW-1:0];
                                n_state   = ST_FETCH;
                            end
                        end
                        oal_pkg::K_NEXT: begin
                            if (i_cmd.position == '0 || i_cmd.position >= r_count) begin
                                n_status = oal_pkg::S_RANGE;
                            end else begin
                                mem_raddr = i_cmd.position[AW-1:0];
                                n_state   = ST_FETCH;
                            end
                        end
                        oal_pkg::K_SORT: begin
                            if (r_count >= CW'(2)) begin
                                n_end   = r_count;
                                n_state = ST_SORT_HEAD;
                            end
                        end
                        oal_pkg::K_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                n_value = mem_rdata;
                if (oal_pkg::t_kind'(r_kind) == oal_pkg::K_DELETE) begin
                    n_idx   = r_pos;
                    n_state = ST_DEL_RD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_INS_RD: begin
                if (r_idx == r_pos) begin
                    mem_wr.en   = 1'b1;
                    mem_wr.addr = r_pos[AW-1:0];
                    mem_wr.data = r_val;
                    n_count     = r_count + CW'(1);
                    n_state     = ST_DONE;
                end else begin
                    mem_raddr = idx_m1[AW-1:0];
                    n_state   = ST_INS_WR;
                end
            end
            ST_INS_WR: begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = r_idx[AW-1:0];
                mem_wr.data = mem_rdata;
                n_idx       = idx_m1;
                n_state     = ST_INS_RD;
            end
            ST_DEL_RD: begin
                if (r_idx == r_count) begin
                    n_count = r_count - CW'(1);
                    n_state = ST_DONE;
                end else begin
                    mem_raddr = r_idx[AW-1:0];
                    n_state   = ST_DEL_WR;
                end
            end
            ST_DEL_WR: begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = idx_m1[AW-1:0];
                mem_wr.data = mem_rdata;
                n_idx       = idx_p1;
                n_state     = ST_DEL_RD;
            end
            ST_SORT_HEAD: begin
                // mem_rdata holds the first element; it is carried as the running max
                n_a     = mem_rdata;
                n_idx   = '0;
                n_state = ST_SORT_RD;
            end
            ST_SORT_RD: begin
                if (idx_p1 == r_end) begin
                    // end of a pass: the carried max lands in the last slot
                    mem_wr.en   = 1'b1;
                    mem_wr.addr = r_idx[AW-1:0];
                    mem_wr.data = r_a;
                    n_end       = r_end - CW'(1);
                    if (r_end == CW'(2)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_SORT_HEAD;
                    end
                end else begin
                    mem_raddr = idx_p1[AW-1:0];
                    n_state   = ST_SORT_CMP;
                end
            end
            ST_SORT_CMP: begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = r_idx[AW-1:0];
                mem_wr.data = a_gt_b ? mem_rdata : r_a;
                n_a         = a_gt_b ? r_a : mem_rdata;
                n_idx       = idx_p1;
                n_state     = ST_SORT_RD;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_end    <= n_end;
        r_pos    <= n_pos;
        r_kind   <= n_kind;
        r_val    <= n_val;
        r_a      <= n_a;
        r_value  <= n_value;
        r_status <= n_status;
    end

    assign busy               = (r_state != ST_IDLE);
    assign o_valid            = (r_state == ST_DONE);
    assign o_result.value_out = r_value;
    assign o_result.status    = r_status;
    assign o_result.count     = r_count;
    assign o_result.is_empty  = (r_count == '0);

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.count <= CW'(oal_pkg::CAPACITY)))
        else $error("list length beyond capacity");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != oal_pkg::S_OK) |-> (o_result.value_out == '0))
        else $error("failed transaction returned a value");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy)
        else $error("engine not idle after result");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_DONE) |-> !mem_wr.en)
        else $error("store written outside an operation");
`endif

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        oal_pkg::t_cmd cmd;
        int            gap;
        bit            drain;
    } t_backlog_entry;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    oal_pkg::t_cmd    i_cmd = '0;
    logic             o_valid;
    oal_pkg::t_result o_result;

    ordered_array_list_engine_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always #10 i_clk = ~i_clk;

    // shadow copy of the list
    logic signed [oal_pkg::DW-1:0] shadow_elems [oal_pkg::CAPACITY];
    int                            shadow_len = 0;

    t_backlog_entry   cmd_backlog [$];
    oal_pkg::t_result expected_results [$];
    int               accepted_n = 0;
    int               planned_n = 0;
    int               plan_len = 0;
    bit               gap_mode = 1'b1;
    bit               failed = 1'b0;
    logic             taken = 1'b0;

    // driver state
    t_backlog_entry stage;
    bit             staged = 1'b0;
    bit             draining = 1'b0;
    int             wait_left = 0;

    function automatic oal_pkg::t_result apply_list_op(oal_pkg::t_cmd c);
        oal_pkg::t_result              r;
        int                            n;
        int                            p;
        logic signed [oal_pkg::DW-1:0] t;
        r = '0;
        n = shadow_len;
        p = c.position;
        r.status = oal_pkg::S_OK;
        case (oal_pkg::t_kind'(c.kind))
            oal_pkg::K_INSERT: begin
                if (p > n) begin
                    r.status = oal_pkg::S_RANGE;
                end else if (n >= oal_pkg::CAPACITY) begin
                    r.status = oal_pkg::S_FULL;
                end else begin
                    for (int i = n; i > p; i--) shadow_elems[i] = shadow_elems[i-1];
                    shadow_elems[p] = c.value_in;
                    shadow_len = n + 1;
                end
            end
            oal_pkg::K_DELETE: begin
                if (p < 1 || p > n) begin
                    r.status = oal_pkg::S_RANGE;
                end else begin
                    r.value_out = shadow_elems[p-1];
                    for (int i = p; i < n; i++) shadow_elems[i-1] = shadow_elems[i];
                    shadow_len = n - 1;
                end
            end
            oal_pkg::K_GET: begin
                if (p < 1 || p > n) r.status = oal_pkg::S_RANGE;
                else r.value_out = shadow_elems[p-1];
            end
            oal_pkg::K_PREV: begin
                if (p < 2 || p > n) r.status = oal_pkg::S_RANGE;
                else r.value_out = shadow_elems[p-2];
            end
            oal_pkg::K_NEXT: begin
                if (p < 1 || p >= n) r.status = oal_pkg::S_RANGE;
                else r.value_out = shadow_elems[p];
            end
            oal_pkg::K_SORT: begin
                for (int a = 0; a + 1 < n; a++) begin
                    for (int b = 0; b + 1 < n - a; b++) begin
                        if (shadow_elems[b] > shadow_elems[b+1]) begin
                            t = shadow_elems[b];
                            shadow_elems[b] = shadow_elems[b+1];
                            shadow_elems[b+1] = t;
                        end
                    end
                end
            end
            oal_pkg::K_CLEAR: shadow_len = 0;
            default: ;
        endcase
        r.count = oal_pkg::CW'(shadow_len);
        r.is_empty = (shadow_len == 0);
        return r;
    endfunction

    // monitor: check results, then predict the transaction taken at this edge
    always @(posedge i_clk) begin
        oal_pkg::t_result exp_r;
        if (i_rst_n) begin
            if (o_valid) begin
                if (expected_results.size() == 0) begin
                    failed = 1'b1;
                    $display("%0t: unexpected result value_out %0d status %0d count %0d",
                             $time, o_result.value_out, o_result.status, o_result.count);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (o_result !== exp_r) begin
                        failed = 1'b1;
                        if (o_result.value_out !== exp_r.value_out)
                            $display("%0t: value_out expected %0d actual %0d", $time,
                                     exp_r.value_out, o_result.value_out);
                        if (o_result.status !== exp_r.status)
                            $display("%0t: status expected %0d actual %0d", $time,
                                     exp_r.status, o_result.status);
                        if (o_result.count !== exp_r.count)
                            $display("%0t: count expected %0d actual %0d", $time,
                                     exp_r.count, o_result.count);
                        if (o_result.is_empty !== exp_r.is_empty)
                            $display("%0t: is_empty expected %0d actual %0d", $time,
                                     exp_r.is_empty, o_result.is_empty);
                    end
                end
            end
            if (start && !busy) begin
                expected_results.push_back(apply_list_op(i_cmd));
                accepted_n++;
            end
        end
        taken <= i_rst_n && start && !busy;
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && !(start && !taken)) begin
            if (!staged && !draining && cmd_backlog.size() != 0) begin
                stage = cmd_backlog.pop_front();
                if (stage.drain) begin
                    draining = 1'b1;
                end else begin
                    staged = 1'b1;
                    wait_left = stage.gap;
                end
            end
            if (draining) begin
                if (expected_results.size() == 0) draining = 1'b0;
                start <= 1'b0;
            end else if (staged && wait_left > 0) begin
                wait_left--;
                start <= 1'b0;
            end else if (staged) begin
                i_cmd <= stage.cmd;
                start <= 1'b1;
                staged = 1'b0;
            end else begin
                start <= 1'b0;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gap_mode || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [oal_pkg::DW-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2, 3: return $urandom_range(0, 15) - 8;
            default: return $urandom();
        endcase
    endfunction

    // mostly legal positions for the kind, sometimes anything
    function automatic int pick_pos(oal_pkg::t_kind k);
        int lo;
        int hi;
        lo = 1;
        hi = plan_len;
        case (k)
            oal_pkg::K_INSERT: lo = 0;
            oal_pkg::K_PREV:   lo = 2;
            oal_pkg::K_NEXT:   hi = plan_len - 1;
            default: ;
        endcase
        if ($urandom_range(0, 99) < 12 || hi < lo) return $urandom_range(0, oal_pkg::CAPACITY);
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? lo : hi;
        return $urandom_range(lo, hi);
    endfunction

    task automatic queue_cmd(oal_pkg::t_kind k, int p, logic [oal_pkg::DW-1:0] v);
        t_backlog_entry e;
        e.cmd.kind = k;
        e.cmd.position = oal_pkg::CW'(p);
        e.cmd.value_in = v;
        e.gap = pick_gap();
        e.drain = 1'b0;
        cmd_backlog.push_back(e);
        planned_n++;
        case (k)
            oal_pkg::K_INSERT: if (p <= plan_len && plan_len < oal_pkg::CAPACITY) plan_len++;
            oal_pkg::K_DELETE: if (p >= 1 && p <= plan_len) plan_len--;
            oal_pkg::K_CLEAR:  plan_len = 0;
            default: ;
        endcase
    endtask

    task automatic queue_drain();
        t_backlog_entry e;
        e.cmd = '0;
        e.gap = 0;
        e.drain = 1'b1;
        cmd_backlog.push_back(e);
    endtask

    task automatic plan_stimulus();
        oal_pkg::t_kind k;
        int             r;
        int             target;
        // empty list corner cases, then a short list with extreme values, range edges, sort, delete and clear
        queue_cmd(oal_pkg::K_GET, 1, '0);
        queue_cmd(oal_pkg::K_DELETE, 0, '0);
        queue_cmd(oal_pkg::K_PREV, 2, '0);
        queue_cmd(oal_pkg::K_NEXT, 1, '0);
        queue_cmd(oal_pkg::K_SORT, 0, '0);
        queue_cmd(oal_pkg::K_NONE, 5, 32'hffff_ffff);
        queue_cmd(oal_pkg::K_INSERT, 1, 32'd7);
        queue_cmd(oal_pkg::K_INSERT, 0, 32'h7fff_ffff);
        queue_cmd(oal_pkg::K_SORT, 0, '0);
        queue_cmd(oal_pkg::K_INSERT, 1, 32'h8000_0000);
        queue_cmd(oal_pkg::K_INSERT, 0, 32'hffff_ffff);
        queue_cmd(oal_pkg::K_INSERT, 3, 32'h0);
        queue_cmd(oal_pkg::K_INSERT, 2, 32'h5555_5555);
        queue_cmd(oal_pkg::K_GET, 5, '0);
        queue_cmd(oal_pkg::K_GET, 6, '0);
        queue_cmd(oal_pkg::K_PREV, 1, '0);
        queue_cmd(oal_pkg::K_PREV, 2, '0);
        queue_cmd(oal_pkg::K_NEXT, 5, '0);
        queue_cmd(oal_pkg::K_NEXT, 4, '0);
        queue_cmd(oal_pkg::K_NEXT, 0, '0);
        queue_cmd(oal_pkg::K_SORT, 0, '0);
        queue_cmd(oal_pkg::K_DELETE, 5, '0);
        queue_cmd(oal_pkg::K_DELETE, 1, '0);
        queue_cmd(oal_pkg::K_NONE, 64, '0);
        queue_cmd(oal_pkg::K_CLEAR, 3, '0);
        queue_drain();

        while (planned_n < 1275) begin
            gap_mode = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    target = ($urandom_range(0, 2) == 0)
                             ? oal_pkg::CAPACITY
                             : $urandom_range(plan_len, oal_pkg::CAPACITY);
                    while (plan_len < target)
                        queue_cmd(oal_pkg::K_INSERT, pick_pos(oal_pkg::K_INSERT), rand_value());
                    if (plan_len == oal_pkg::CAPACITY) begin
                        queue_cmd(oal_pkg::K_INSERT, $urandom_range(0, oal_pkg::CAPACITY),
                                  rand_value());
                        queue_cmd(oal_pkg::K_INSERT, oal_pkg::CAPACITY, rand_value());
                        queue_cmd(oal_pkg::K_GET, oal_pkg::CAPACITY, '0);
                        queue_cmd(oal_pkg::K_PREV, oal_pkg::CAPACITY, '0);
                        queue_cmd(oal_pkg::K_NEXT, oal_pkg::CAPACITY - 1, '0);
                    end
                end
                3, 4, 5, 6: begin
                    repeat (30) begin
                        r = $urandom_range(0, 99);
                        if (r < 35)      k = oal_pkg::K_INSERT;
                        else if (r < 55) k = oal_pkg::K_DELETE;
                        else if (r < 68) k = oal_pkg::K_GET;
                        else if (r < 78) k = oal_pkg::K_PREV;
                        else if (r < 88) k = oal_pkg::K_NEXT;
                        else if (r < 90) k = oal_pkg::K_SORT;
                        else if (r < 92) k = oal_pkg::K_CLEAR;
                        else if (r < 94) k = oal_pkg::K_NONE;
                        else             k = oal_pkg::K_GET;
                        queue_cmd(k, pick_pos(k), rand_value());
                    end
                end
                7: begin
                    queue_cmd(oal_pkg::K_SORT, $urandom_range(0, oal_pkg::CAPACITY), rand_value());
                    for (int i = 1; i <= plan_len; i++)
                        queue_cmd(oal_pkg::K_GET, i, rand_value());
                end
                8: begin
                    repeat ($urandom_range(1, plan_len + 2))
                        queue_cmd(oal_pkg::K_DELETE, pick_pos(oal_pkg::K_DELETE), rand_value());
                end
                default: begin
                    if ($urandom_range(0, 1))
                        queue_cmd(oal_pkg::K_CLEAR, pick_pos(oal_pkg::K_GET), rand_value());
                    else
                        queue_cmd(oal_pkg::K_NONE, pick_pos(oal_pkg::K_GET), rand_value());
                end
            endcase
            if ($urandom_range(0, 4) == 0) queue_drain();
        end
    endtask

    initial begin
        plan_stimulus();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (accepted_n < planned_n || expected_results.size() != 0) @(negedge i_clk);
        // catch any stray strobe after the last transaction
        repeat (20) @(negedge i_clk);
        if (!failed)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #60ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
sv/oal_pkg.sv
sv/oal_store.sv
sv/ordered_array_list_engine_core.sv
verif/tb_top.sv
